/* hdl/npcm_pkg.sv */
package npcm_pkg;

   localparam int COLOR_W = 24;
   localparam int SAD_W   = 10;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;

   localparam logic [2:0] ST_MAPPED  = 3'd0;
   localparam logic [2:0] ST_ADDED   = 3'd1;
   localparam logic [2:0] ST_DUP     = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] comp_a;
      logic [7:0] comp_b;
      logic [7:0] comp_c;
   } npcm_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_a;
      logic [7:0] out_b;
      logic [7:0] out_c;
   } npcm_rsp_type;

   typedef struct packed {
      logic               active;
      logic [1:0]         cmd;
      logic [COLOR_W-1:0] color;
      logic [COLOR_W-1:0] best;
      logic [SAD_W-1:0]   best_d;
      logic               found;
      logic               added;
   } npcm_token_type;

   function automatic logic [7:0] absdiff8(input logic [7:0] x, input logic [7:0] y);
      return (x > y) ? (x - y) : (y - x);
   endfunction

   function automatic logic [SAD_W-1:0] sad24(input logic [COLOR_W-1:0] p,
                                              input logic [COLOR_W-1:0] q);
      logic [7:0] da;
      logic [7:0] db;
      logic [7:0] dc;
      da = absdiff8(p[23:16], q[23:16]);
      db = absdiff8(p[15:8], q[15:8]);
      dc = absdiff8(p[7:0], q[7:0]);
      return SAD_W'(da) + SAD_W'(db) + SAD_W'(dc);
   endfunction

endpackage

/* hdl/npcm_cell.sv */
module npcm_cell
   import npcm_pkg::*;
#(
   parameter int COUNT_W    = 9,
   parameter int CELL_INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [COUNT_W-1:0] count,
   input  npcm_token_type tok_in,
   output npcm_token_type tok_out
);

   logic [COLOR_W-1:0] entry_ff;
   npcm_token_type     tok_ff;
   npcm_token_type     tok_in_next;
   logic               slot_live;
   logic               slot_free;
   logic               is_add;
   logic               do_write;
   logic [SAD_W-1:0]   d;

   assign slot_live = COUNT_W'(CELL_INDEX) < count;
   assign slot_free = COUNT_W'(CELL_INDEX) == count;
   assign is_add    = (tok_in.cmd == CMD_ADD);
   assign do_write  = tok_in.active && is_add && slot_free && !tok_in.found;
   assign d         = sad24(tok_in.color, entry_ff);

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.active && slot_live) begin
         if (is_add) begin
            if (entry_ff == tok_in.color) begin
               tok_in_next.found = 1'b1;
            end
         end else if (tok_in.cmd != CMD_CLEAR) begin
            if ((d < tok_in.best_d) || ((d == tok_in.best_d) && (entry_ff < tok_in.best))) begin
               tok_in_next.best   = entry_ff;
               tok_in_next.best_d = d;
            end
         end
      end
      if (do_write) begin
         tok_in_next.added = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff <= tok_in.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* hdl/nearest_palette_color_mapper.sv */
// One transaction at a time: req_ready drops when a transaction is taken and rises
// again when its result moves from the result register to the output register. Each
// item walks the palette cell chain one cell per cycle, then passes a result stage.
// A finished result may wait in the output register while the next transaction runs.
// Reset: synchronous, active high; clears the palette count and all handshake state.
module nearest_palette_color_mapper
   import npcm_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  npcm_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output npcm_rsp_type rsp_data
);

   localparam int COUNT_W = $clog2(PALETTE_DEPTH + 1);

   logic               busy_ff;
   logic               busy_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               res_valid_ff;
   logic               res_valid_in;
   npcm_rsp_type       res_ff;
   npcm_rsp_type       res_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   npcm_rsp_type       rsp_ff;
   npcm_token_type     feed;
   npcm_token_type     chain_tok [PALETTE_DEPTH];
   npcm_token_type     exit_tok;
   logic [PALETTE_DEPTH-1:0] active_vec;
   logic               req_fire;
   logic               res_move;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign res_move  = res_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      feed        = '0;
      feed.active = req_fire;
      feed.cmd    = req_data.cmd;
      feed.color  = {req_data.comp_a, req_data.comp_b, req_data.comp_c};
      feed.best   = '1;
      feed.best_d = '1;
   end

   genvar k;
   generate
      for (k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
         npcm_cell #(
            .COUNT_W    (COUNT_W),
            .CELL_INDEX (k)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .count   (count_ff),
            .tok_in  ((k == 0) ? feed : chain_tok[(k == 0) ? 0 : k - 1]),
            .tok_out (chain_tok[k])
         );
         assign active_vec[k] = chain_tok[k].active;
      end
   endgenerate

   assign exit_tok = chain_tok[PALETTE_DEPTH-1];

   always_comb begin
      res_in   = '0;
      count_in = count_ff;
      case (exit_tok.cmd)
         CMD_CLEAR: begin
            res_in.status = ST_CLEARED;
            count_in      = '0;
         end
         CMD_ADD: begin
            if (exit_tok.found) begin
               res_in.status = ST_DUP;
            end else if (exit_tok.added) begin
               res_in.status = ST_ADDED;
               count_in      = count_ff + COUNT_W'(1);
            end else begin
               res_in.status = ST_FULL;
            end
         end
         default: begin
            if (count_ff == '0) begin
               res_in.status = ST_EMPTY;
            end else begin
               res_in.status = ST_MAPPED;
               res_in.out_a  = exit_tok.best[23:16];
               res_in.out_b  = exit_tok.best[15:8];
               res_in.out_c  = exit_tok.best[7:0];
            end
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (res_move) begin
         busy_in = 1'b0;
      end
      res_valid_in = res_valid_ff;
      if (exit_tok.active) begin
         res_valid_in = 1'b1;
      end else if (res_move) begin
         res_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (res_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exit_tok.active) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exit_tok.active) begin
         res_ff <= res_in;
      end
      if (res_move) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(PALETTE_DEPTH))
      else $error("palette count above depth");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(active_vec) <= 1)
      else $error("more than one transaction in the cell chain");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (active_vec != '0) || res_valid_ff |-> busy_ff)
      else $error("work in flight while not busy");

   a_exit_to_res: assert property (@(posedge clock) disable iff (reset)
      exit_tok.active |=> res_valid_ff)
      else $error("chain exit not captured");

   a_add_room: assert property (@(posedge clock) disable iff (reset)
      exit_tok.active && exit_tok.added |-> count_ff < COUNT_W'(PALETTE_DEPTH))
      else $error("entry added to a full palette");
`endif

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import npcm_pkg::*;

   localparam int          DEPTH          = 256;
   localparam int unsigned ITEM_TARGET    = 1150;
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned STALL_CYCLES   = 2000;
   localparam logic [1:0]  CMD_MAP        = 2'd2;
   localparam logic [1:0]  CMD_MAP_ALT    = 2'd3;

   class palette_scoreboard;
      logic [COLOR_W-1:0] palette [DEPTH];
      int unsigned        entry_count;
      int unsigned        peak_count;
      npcm_rsp_type       pending_results [$];
      int unsigned        mismatches;
      int unsigned        status_seen [8];

      function automatic int unsigned color_distance(logic [COLOR_W-1:0] p,
                                                     logic [COLOR_W-1:0] q);
         int unsigned total;
         int          diff;
         total = 0;
         for (int k = 0; k < 3; k++) begin
            diff = int'(p[8*k +: 8]) - int'(q[8*k +: 8]);
            total += (diff < 0) ? -diff : diff;
         end
         return total;
      endfunction

      function automatic void note_request(npcm_req_type req);
         npcm_rsp_type       rsp;
         logic [COLOR_W-1:0] color;
         logic [COLOR_W-1:0] best;
         int unsigned        best_d;
         int unsigned        d;
         bit                 found;
         color = {req.comp_a, req.comp_b, req.comp_c};
         rsp   = '0;
         if (req.cmd == CMD_CLEAR) begin
            entry_count = 0;
            rsp.status  = ST_CLEARED;
         end else if (req.cmd == CMD_ADD) begin
            found = 1'b0;
            for (int i = 0; i < entry_count; i++) begin
               if (palette[i] == color) found = 1'b1;
            end
            if (found) begin
               rsp.status = ST_DUP;
            end else if (entry_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               palette[entry_count] = color;
               entry_count++;
               if (entry_count > peak_count) peak_count = entry_count;
               rsp.status = ST_ADDED;
            end
         end else if (entry_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            best   = palette[0];
            best_d = color_distance(color, best);
            for (int i = 1; i < entry_count; i++) begin
               d = color_distance(color, palette[i]);
               if (d < best_d || (d == best_d && palette[i] < best)) begin
                  best   = palette[i];
                  best_d = d;
               end
            end
            {rsp.out_a, rsp.out_b, rsp.out_c} = best;
            rsp.status = ST_MAPPED;
         end
         pending_results.insert(pending_results.size(), rsp);
      endfunction

      function automatic void check_response(npcm_rsp_type got);
         npcm_rsp_type want;
         if (got.status < 8) status_seen[got.status]++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result status %0d color %02h%02h%02h",
                        got.status, got.out_a, got.out_b, got.out_c);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.out_a !== want.out_a ||
             got.out_b !== want.out_b || got.out_c !== want.out_c) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: expected status %0d color %02h%02h%02h, ",
                         "got status %0d color %02h%02h%02h"},
                        want.status, want.out_a, want.out_b, want.out_c,
                        got.status, got.out_a, got.out_b, got.out_c);
         end
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   npcm_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   npcm_rsp_type rsp_data;

   palette_scoreboard sb = new();
   int unsigned       items_sent    = 0;
   int unsigned       idle_cycles   = 0;
   bit                no_idle       = 1'b0;
   bit                stall_request = 1'b0;

   nearest_palette_color_mapper #(
      .PALETTE_DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic logic [COLOR_W-1:0] pick_color(bit narrow);
      logic [COLOR_W-1:0] color;
      color = COLOR_W'($urandom);
      if (narrow) begin
         for (int k = 0; k < 3; k++)
            color[8*k +: 8] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                          : 8'($urandom_range(252, 255));
      end
      return color;
   endfunction

   task automatic send_color(logic [1:0] cmd, logic [COLOR_W-1:0] color);
      npcm_req_type item;
      int unsigned  gap;
      item.cmd = cmd;
      {item.comp_a, item.comp_b, item.comp_c} = color;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic send_duplicate();
      send_color(CMD_ADD, sb.palette[$urandom_range(0, sb.entry_count - 1)]);
   endtask

   initial begin
      int unsigned hold;
      @(negedge clock iff !reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 5);
         if (stall_request) begin
            hold          = STALL_CYCLES;
            stall_request = 1'b0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

   initial begin
      int unsigned n_adds;
      int unsigned n_maps;
      int unsigned pick;
      bit          narrow;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_color(CMD_MAP, 24'h000000);
      send_color(CMD_MAP_ALT, 24'hFFFFFF);
      send_color(CMD_ADD, 24'hFFFFFF);
      send_color(CMD_MAP, 24'h000000);
      send_color(CMD_ADD, 24'h000000);
      send_color(CMD_ADD, 24'h000000);
      send_color(CMD_MAP, 24'h808080);
      send_color(CMD_MAP, 24'h7F7F7F);
      send_color(CMD_MAP_ALT, 24'hFFFFFF);
      send_color(CMD_CLEAR, 24'hA5C35A);
      send_color(CMD_MAP, 24'h123456);
      send_color(CMD_ADD, 24'h020000);
      send_color(CMD_ADD, 24'h000002);
      send_color(CMD_MAP, 24'h010001);
      send_color(CMD_MAP_ALT, 24'h010001);
      send_color(CMD_ADD, 24'h00FF00);
      send_color(CMD_MAP, 24'h80FF80);
      send_color(CMD_ADD, 24'hAA55AA);
      send_color(CMD_ADD, 24'h55AA55);
      send_color(CMD_MAP, 24'hAA55AA);
      send_color(CMD_ADD, 24'h55AA55);
      send_color(CMD_CLEAR, 24'h000000);
      send_color(CMD_MAP_ALT, 24'h000000);

      // fill the palette to its limit, stalling the result side on the way at 20 entries
      send_color(CMD_CLEAR, COLOR_W'($urandom));
      while (sb.entry_count < DEPTH) begin
         if (sb.entry_count == 20) stall_request = 1'b1;
         pick = $urandom_range(0, 15);
         if (pick == 0) send_color(CMD_MAP, COLOR_W'($urandom));
         else if (pick == 1 && sb.entry_count > 0) send_duplicate();
         else send_color(CMD_ADD, COLOR_W'($urandom));
      end
      for (int k = 0; k < 24; k++) begin
         case (k % 3)
            0: send_color(CMD_ADD, COLOR_W'($urandom));
            1: send_duplicate();
            default: send_color(CMD_MAP, COLOR_W'($urandom));
         endcase
      end

      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         narrow  = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 4) != 0) send_color(CMD_CLEAR, COLOR_W'($urandom));
         n_adds = $urandom_range(0, 24);
         for (int k = 0; k < n_adds; k++) begin
            if ($urandom_range(0, 4) == 0 && sb.entry_count > 0) send_duplicate();
            else send_color(CMD_ADD, pick_color(narrow));
         end
         n_maps = $urandom_range(4, 30);
         for (int k = 0; k < n_maps; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_color(CMD_ADD, pick_color(narrow));
            else if (pick == 1) send_color(CMD_MAP_ALT, pick_color(narrow));
            else if (pick == 2) send_color(CMD_CLEAR, COLOR_W'($urandom));
            else if (pick == 3 && sb.entry_count > 0)
               send_color(CMD_MAP, sb.palette[$urandom_range(0, sb.entry_count - 1)]);
            else send_color(CMD_MAP, pick_color(narrow));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 16) @(posedge clock);

      $display("Sent %0d transactions, palette peak %0d of %0d entries.",
               items_sent, sb.peak_count, DEPTH);
      $display({"Results: %0d mapped, %0d added, %0d duplicate, %0d full, ",
                "%0d cleared, %0d empty; %0d mismatches."},
               sb.status_seen[ST_MAPPED], sb.status_seen[ST_ADDED], sb.status_seen[ST_DUP],
               sb.status_seen[ST_FULL], sb.status_seen[ST_CLEARED], sb.status_seen[ST_EMPTY],
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/npcm_pkg.sv
hdl/npcm_cell.sv
hdl/nearest_palette_color_mapper.sv
bench/tb_top.sv
